// ===== design/lagged_subtractive_random_generator_assert.svh =====
// ----------------------------------------------------------------------------
// lagged subtractive generator assertion macros
// shorthand for clocked implication checks, reset-qualified on rst_n
// ----------------------------------------------------------------------------
`ifndef LAGGED_SUBTRACTIVE_RANDOM_GENERATOR_ASSERT_SVH
`define LAGGED_SUBTRACTIVE_RANDOM_GENERATOR_ASSERT_SVH

// same-cycle implication
`define LSRG_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lsrg: check failed");

// next-cycle implication
`define LSRG_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lsrg: check failed");

`endif

// ===== design/lsrg_pkg.sv =====
// ----------------------------------------------------------------------------
// lsrg_pkg
// constants, codes, microcode format and microcode rom of the lagged
// subtractive random generator
// ----------------------------------------------------------------------------
package lsrg_pkg;

    localparam int FRAC_BITS   = 32;
    localparam int DATA_W      = 32;
    localparam int LAG_LEN     = 55;
    localparam int LAG_LONG    = 24;
    localparam int LAG_SHORT   = LAG_LEN - LAG_LONG;
    localparam int WARM_STRIDE = 21;
    localparam int FILL_PASSES = 3;
    localparam int ADDR_W      = $clog2(LAG_LEN);
    localparam int PASS_W      = $clog2(FILL_PASSES + 1);
    localparam int SPAN_W      = DATA_W + 1;
    localparam int PROD_W      = FRAC_BITS + SPAN_W;

    // exp(-9) in q0.32
    localparam logic [DATA_W-1:0] EXP_M9_Q32 = 32'd530041;
    localparam logic [DATA_W-1:0] SEED_RESET = '1;

    typedef enum logic [1:0] {
        CMD_RESEED,
        CMD_DRAW,
        CMD_DRAW_INT,
        CMD_UNUSED
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_RANGE_ERR,
        STAT_RESEED_DONE
    } status_t;

    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_WARM_INIT,
        STEP_WARM,
        STEP_FILL,
        STEP_AFTER_FILL,
        STEP_RESEED_DONE,
        STEP_DRAW,
        STEP_MUL,
        STEP_SCALE,
        STEP_RESP
    } step_t;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_ACCEPT,
        UOP_WARM_INIT,
        UOP_WARM,
        UOP_FILL,
        UOP_RESEED_DONE,
        UOP_DRAW,
        UOP_MUL,
        UOP_SCALE,
        UOP_RESP
    } uop_t;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_DISPATCH,
        SEQ_LOOP_WARM,
        SEQ_LOOP_FILL,
        SEQ_AFTER_FILL,
        SEQ_IF_RESP,
        SEQ_DRAW,
        SEQ_WAIT_OUT
    } seq_t;

    typedef struct packed {
        uop_t  uop;
        seq_t  seq;
        step_t target;
    } ctrl_word_t;

    // q0.32 to table format, truncating
    function automatic logic [FRAC_BITS-1:0] q32_to_frac(input logic [DATA_W-1:0] q);
        logic [FRAC_BITS+DATA_W-1:0] wide;
        wide = {q, {FRAC_BITS{1'b0}}};
        return wide[FRAC_BITS+DATA_W-1 -: FRAC_BITS];
    endfunction

    // table format to q0.32, truncating
    function automatic logic [DATA_W-1:0] frac_to_q32(input logic [FRAC_BITS-1:0] f);
        logic [FRAC_BITS+DATA_W-1:0] wide;
        wide = {f, {DATA_W{1'b0}}};
        return wide[FRAC_BITS+DATA_W-1 -: DATA_W];
    endfunction

    // microcode program
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t w;
        case (step)
            STEP_IDLE:        w = '{UOP_ACCEPT,      SEQ_DISPATCH,   STEP_IDLE};
            STEP_WARM_INIT:   w = '{UOP_WARM_INIT,   SEQ_NEXT,       STEP_WARM};
            STEP_WARM:        w = '{UOP_WARM,        SEQ_LOOP_WARM,  STEP_FILL};
            STEP_FILL:        w = '{UOP_FILL,        SEQ_LOOP_FILL,  STEP_AFTER_FILL};
            STEP_AFTER_FILL:  w = '{UOP_NONE,        SEQ_AFTER_FILL, STEP_RESEED_DONE};
            STEP_RESEED_DONE: w = '{UOP_RESEED_DONE, SEQ_IF_RESP,    STEP_RESP};
            STEP_DRAW:        w = '{UOP_DRAW,        SEQ_DRAW,       STEP_MUL};
            STEP_MUL:         w = '{UOP_MUL,         SEQ_NEXT,       STEP_SCALE};
            STEP_SCALE:       w = '{UOP_SCALE,       SEQ_NEXT,       STEP_RESP};
            STEP_RESP:        w = '{UOP_RESP,        SEQ_WAIT_OUT,   STEP_IDLE};
            default:          w = '{UOP_NONE,        SEQ_NEXT,       STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== design/lsrg_ram.sv =====
// ----------------------------------------------------------------------------
// lsrg_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module lsrg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== design/lagged_subtractive_random_generator.sv =====
// ----------------------------------------------------------------------------
// lagged_subtractive_random_generator
// subtractive lagged generator (lags 55 and 24) with fraction and range draws
// ----------------------------------------------------------------------------
// One request at a time, run by a microcode sequencer over a 55-word table in
// a ram with one write and two read ports. A fraction or integer draw passes
// from acceptance through its table read, multiply, scale and result steps,
// and a new request is taken only once the result step is left. The draw that
// finds the read pointer at the end of the table (the 55th after a reseed,
// then every 54th) refills the table first: 54 entries at one per cycle
// through the ram ports, then two sequencing steps. An integer draw with equal
// or inverted bounds goes straight from acceptance to the result step. A
// reseed runs 55 warmup writes, three refill passes of 54 entries, then the
// after-fill and reseed-done steps before its result step. A result held in
// the output register stalls the sequencer at its result step until it is
// taken. After reset the same reseed runs before the first request is taken.
// The seed register can be written at any time and is used by the next reseed.
module lagged_subtractive_random_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lsrg_pkg::DATA_W-1:0] cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic [lsrg_pkg::DATA_W-1:0] range_low,
    input  logic [lsrg_pkg::DATA_W-1:0] range_high,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lsrg_pkg::DATA_W-1:0] fraction,
    output logic [lsrg_pkg::DATA_W-1:0] value,
    output logic [1:0]                  status
);

    import lsrg_pkg::*;

    ctrl_word_t ctrl;

    logic [DATA_W-1:0]    seed_reg, seed_next;
    step_t                pc_reg, pc_next;
    cmd_t                 cmd_reg, cmd_next;
    logic                 req_seen_reg, req_seen_next;
    logic [DATA_W-1:0]    lo_reg, lo_next;
    logic [DATA_W-1:0]    hi_reg, hi_next;
    logic [SPAN_W-1:0]    span_reg, span_next;
    logic [FRAC_BITS-1:0] warm_prev_reg, warm_prev_next;
    logic [FRAC_BITS-1:0] warm_cur_reg, warm_cur_next;
    logic [ADDR_W-1:0]    warm_addr_reg, warm_addr_next;
    logic [ADDR_W-1:0]    warm_cnt_reg, warm_cnt_next;
    logic [ADDR_W-1:0]    fill_k_reg, fill_k_next;
    logic [PASS_W-1:0]    passes_reg, passes_next;
    logic                 wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0]    wb_addr_reg, wb_addr_next;
    logic [ADDR_W-1:0]    read_index_reg, read_index_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [DATA_W-1:0]    res_fraction_reg, res_fraction_next;
    logic [DATA_W-1:0]    res_value_reg, res_value_next;
    status_t              res_status_reg, res_status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    out_fraction_reg, out_fraction_next;
    logic [DATA_W-1:0]    out_value_reg, out_value_next;
    status_t              out_status_reg, out_status_next;

    logic                 accept;
    logic                 out_free;
    logic                 warm_we;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [FRAC_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr_a;
    logic [ADDR_W-1:0]    ram_raddr_b;
    logic [FRAC_BITS-1:0] ram_rdata_a;
    logic [FRAC_BITS-1:0] ram_rdata_b;
    logic [ADDR_W:0]      warm_sum;
    logic [SPAN_W-1:0]    span_calc;
    logic [DATA_W+1:0]    scaled_sum;
    logic [DATA_W+1:0]    hi_ext;

    assign ctrl     = ucode_rom(pc_reg);
    assign in_ready = (ctrl.uop == UOP_ACCEPT);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign fraction  = out_fraction_reg;
    assign value     = out_value_reg;
    assign status    = out_status_reg;

    // table ram
    assign warm_we     = (ctrl.uop == UOP_WARM_INIT) || (ctrl.uop == UOP_WARM);
    assign ram_we      = warm_we || wb_valid_reg;
    assign ram_raddr_a = (ctrl.uop == UOP_FILL) ? fill_k_reg : read_index_reg;
    assign ram_raddr_b = (fill_k_reg < ADDR_W'(LAG_LONG))
                         ? fill_k_reg + ADDR_W'(LAG_SHORT)
                         : fill_k_reg - ADDR_W'(LAG_LONG);

    always_comb
    begin
        case (ctrl.uop)
            UOP_WARM_INIT:
            begin
                ram_waddr = ADDR_W'(LAG_LEN - 1);
                ram_wdata = q32_to_frac(seed_reg);
            end
            UOP_WARM:
            begin
                ram_waddr = warm_addr_reg;
                ram_wdata = warm_cur_reg;
            end
            default:
            begin
                ram_waddr = wb_addr_reg;
                ram_wdata = ram_rdata_a - ram_rdata_b;
            end
        endcase
    end

    lsrg_ram #(
        .WIDTH (FRAC_BITS),
        .DEPTH (LAG_LEN)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    // arithmetic helpers
    assign warm_sum   = {1'b0, warm_addr_reg} + (ADDR_W + 1)'(WARM_STRIDE);
    assign span_calc  = {range_high[DATA_W-1], range_high}
                        - {range_low[DATA_W-1], range_low} + SPAN_W'(1);
    assign scaled_sum = {{2{lo_reg[DATA_W-1]}}, lo_reg}
                        + {2'b00, prod_reg[FRAC_BITS +: DATA_W]};
    assign hi_ext     = {{2{hi_reg[DATA_W-1]}}, hi_reg};

    // sequencer: next step
    always_comb
    begin
        pc_next = ctrl.target;
        case (ctrl.seq)
            SEQ_NEXT:
            begin
                pc_next = ctrl.target;
            end
            SEQ_DISPATCH:
            begin
                if (accept)
                begin
                    case (cmd_t'(cmd))
                        CMD_RESEED:   pc_next = STEP_WARM_INIT;
                        CMD_DRAW:     pc_next = STEP_DRAW;
                        CMD_DRAW_INT:
                        begin
                            if ($signed(range_low) >= $signed(range_high))
                            begin
                                pc_next = STEP_RESP;
                            end
                            else
                            begin
                                pc_next = STEP_DRAW;
                            end
                        end
                        default:      pc_next = STEP_IDLE;
                    endcase
                end
            end
            SEQ_LOOP_WARM:
            begin
                pc_next = (warm_cnt_reg == ADDR_W'(LAG_LEN - 2)) ? ctrl.target : pc_reg;
            end
            SEQ_LOOP_FILL:
            begin
                pc_next = (fill_k_reg == ADDR_W'(LAG_LEN - 2) && passes_reg == PASS_W'(1))
                          ? ctrl.target : pc_reg;
            end
            SEQ_AFTER_FILL:
            begin
                pc_next = (cmd_reg == CMD_DRAW || cmd_reg == CMD_DRAW_INT)
                          ? STEP_DRAW : ctrl.target;
            end
            SEQ_IF_RESP:
            begin
                pc_next = req_seen_reg ? ctrl.target : STEP_IDLE;
            end
            SEQ_DRAW:
            begin
                pc_next = (read_index_reg == ADDR_W'(LAG_LEN - 1)) ? STEP_FILL : ctrl.target;
            end
            SEQ_WAIT_OUT:
            begin
                pc_next = out_free ? ctrl.target : pc_reg;
            end
            default:
            begin
                pc_next = STEP_IDLE;
            end
        endcase
    end

    // datapath controlled by the micro-op
    always_comb
    begin
        seed_next         = cfg_wr_en ? cfg_wr_data : seed_reg;
        cmd_next          = cmd_reg;
        req_seen_next     = req_seen_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        span_next         = span_reg;
        warm_prev_next    = warm_prev_reg;
        warm_cur_next     = warm_cur_reg;
        warm_addr_next    = warm_addr_reg;
        warm_cnt_next     = warm_cnt_reg;
        fill_k_next       = fill_k_reg;
        passes_next       = passes_reg;
        wb_valid_next     = 1'b0;
        wb_addr_next      = wb_addr_reg;
        read_index_next   = read_index_reg;
        frac_next         = frac_reg;
        prod_next         = prod_reg;
        res_fraction_next = res_fraction_reg;
        res_value_next    = res_value_reg;
        res_status_next   = res_status_reg;

        case (ctrl.uop)
            UOP_ACCEPT:
            begin
                if (accept)
                begin
                    cmd_next          = cmd_t'(cmd);
                    req_seen_next     = 1'b1;
                    lo_next           = range_low;
                    hi_next           = range_high;
                    span_next         = span_calc;
                    res_fraction_next = '0;
                    res_value_next    = '0;
                    res_status_next   = STAT_OK;
                    if ($signed(range_low) > $signed(range_high))
                    begin
                        res_status_next = STAT_RANGE_ERR;
                    end
                    else if (range_low == range_high)
                    begin
                        res_value_next = range_low;
                    end
                end
            end
            UOP_WARM_INIT:
            begin
                warm_prev_next = q32_to_frac(seed_reg);
                warm_cur_next  = q32_to_frac(EXP_M9_Q32);
                warm_addr_next = ADDR_W'(WARM_STRIDE - 1);
                warm_cnt_next  = '0;
                fill_k_next    = '0;
                passes_next    = PASS_W'(FILL_PASSES);
            end
            UOP_WARM:
            begin
                warm_prev_next = warm_cur_reg;
                warm_cur_next  = warm_prev_reg - warm_cur_reg;
                // stride 21 modulo 55
                if (warm_sum >= (ADDR_W + 1)'(LAG_LEN))
                begin
                    warm_addr_next = ADDR_W'(warm_sum - (ADDR_W + 1)'(LAG_LEN));
                end
                else
                begin
                    warm_addr_next = warm_sum[ADDR_W-1:0];
                end
                warm_cnt_next = warm_cnt_reg + ADDR_W'(1);
            end
            UOP_FILL:
            begin
                // write-back of entry k lands in the cycle after its reads
                wb_valid_next = 1'b1;
                wb_addr_next  = fill_k_reg;
                if (fill_k_reg == ADDR_W'(LAG_LEN - 2))
                begin
                    fill_k_next = '0;
                    passes_next = passes_reg - PASS_W'(1);
                end
                else
                begin
                    fill_k_next = fill_k_reg + ADDR_W'(1);
                end
            end
            UOP_RESEED_DONE:
            begin
                read_index_next   = '0;
                res_fraction_next = '0;
                res_value_next    = '0;
                res_status_next   = STAT_RESEED_DONE;
            end
            UOP_DRAW:
            begin
                if (read_index_reg == ADDR_W'(LAG_LEN - 1))
                begin
                    read_index_next = '0;
                    fill_k_next     = '0;
                    passes_next     = PASS_W'(1);
                end
                else
                begin
                    read_index_next = read_index_reg + ADDR_W'(1);
                end
            end
            UOP_MUL:
            begin
                frac_next = ram_rdata_a;
                prod_next = PROD_W'(ram_rdata_a) * PROD_W'(span_reg);
            end
            UOP_SCALE:
            begin
                res_fraction_next = frac_to_q32(frac_reg);
                res_status_next   = STAT_OK;
                if (cmd_reg == CMD_DRAW_INT)
                begin
                    if ($signed(scaled_sum) > $signed(hi_ext))
                    begin
                        res_value_next = hi_reg;
                    end
                    else
                    begin
                        res_value_next = scaled_sum[DATA_W-1:0];
                    end
                end
                else
                begin
                    res_value_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next    = out_valid_reg && !out_ready;
        out_fraction_next = out_fraction_reg;
        out_value_next    = out_value_reg;
        out_status_next   = out_status_reg;
        if (ctrl.uop == UOP_RESP && out_free)
        begin
            out_valid_next    = 1'b1;
            out_fraction_next = res_fraction_reg;
            out_value_next    = res_value_reg;
            out_status_next   = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= SEED_RESET;
            pc_reg         <= STEP_WARM_INIT;
            cmd_reg        <= CMD_RESEED;
            req_seen_reg   <= 1'b0;
            warm_addr_reg  <= '0;
            warm_cnt_reg   <= '0;
            fill_k_reg     <= '0;
            passes_reg     <= '0;
            wb_valid_reg   <= 1'b0;
            read_index_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            seed_reg       <= seed_next;
            pc_reg         <= pc_next;
            cmd_reg        <= cmd_next;
            req_seen_reg   <= req_seen_next;
            warm_addr_reg  <= warm_addr_next;
            warm_cnt_reg   <= warm_cnt_next;
            fill_k_reg     <= fill_k_next;
            passes_reg     <= passes_next;
            wb_valid_reg   <= wb_valid_next;
            read_index_reg <= read_index_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg           <= lo_next;
        hi_reg           <= hi_next;
        span_reg         <= span_next;
        warm_prev_reg    <= warm_prev_next;
        warm_cur_reg     <= warm_cur_next;
        wb_addr_reg      <= wb_addr_next;
        frac_reg         <= frac_next;
        prod_reg         <= prod_next;
        res_fraction_reg <= res_fraction_next;
        res_value_reg    <= res_value_next;
        res_status_reg   <= res_status_next;
        out_fraction_reg <= out_fraction_next;
        out_value_reg    <= out_value_next;
        out_status_reg   <= out_status_next;
    end

    `include "lagged_subtractive_random_generator_assert.svh"

    `LSRG_ASSERT_IMP(a_no_write_clash, wb_valid_reg, !warm_we)
    `LSRG_ASSERT_IMP(a_index_range, 1'b1, read_index_reg < ADDR_W'(LAG_LEN))
    `LSRG_ASSERT_NXT(a_accept_leaves_idle, accept && cmd != CMD_UNUSED, pc_reg != STEP_IDLE)
    `LSRG_ASSERT_IMP(a_result_from_resp, $rose(out_valid_reg), $past(pc_reg) == STEP_RESP)

endmodule
